[rtl/core/polar_to_cartesian_compass_defines.svh]
// Assertion macros for the compass polar to Cartesian converter.
`ifndef POLAR_TO_CARTESIAN_COMPASS_DEFINES_SVH
`define POLAR_TO_CARTESIAN_COMPASS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define P2CC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define P2CC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/p2cc_pkg.sv]
// Shared constants and the quarter-wave sine table of the compass converter.
`default_nettype none

package p2cc_pkg;

  localparam int AZ_WIDTH      = 11;
  localparam int MAG_WIDTH_DEF = 13;
  localparam int SINE_FRAC_DEF = 16;
  localparam int ROM_FRAC      = 16;
  localparam int SINE_FRAC_MAX = 30;
  localparam int ROM_W         = SINE_FRAC_MAX + 1;

  localparam int HALF_TURN    = 180;
  localparam int FULL_TURN    = 360;
  localparam int QUARTER_TURN = 90;

  // Angle 0..449, offset heading sum below 4096, table index 0..90
  localparam int ANG_W = 9;
  localparam int SUM_W = 12;
  localparam int IDX_W = 7;

  // Pipeline depth from input transfer to output register
  localparam int NSTG = 6;

  // Look up |sin(k deg)| and bring it to frac fraction bits
  function automatic logic [ROM_W-1:0] sine_rom(input logic [IDX_W-1:0] k,
                                                 input int unsigned frac);
    logic [16:0]      q;
    logic [ROM_W-1:0] w;
    int unsigned      dn;
    case (k)
      7'd0:  q = 17'd0;     7'd1:  q = 17'd1144;  7'd2:  q = 17'd2287;  7'd3:  q = 17'd3430;
      7'd4:  q = 17'd4572;  7'd5:  q = 17'd5712;  7'd6:  q = 17'd6850;  7'd7:  q = 17'd7987;
      7'd8:  q = 17'd9121;  7'd9:  q = 17'd10252; 7'd10: q = 17'd11380; 7'd11: q = 17'd12505;
      7'd12: q = 17'd13626; 7'd13: q = 17'd14742; 7'd14: q = 17'd15855; 7'd15: q = 17'd16962;
      7'd16: q = 17'd18064; 7'd17: q = 17'd19161; 7'd18: q = 17'd20252; 7'd19: q = 17'd21336;
      7'd20: q = 17'd22415; 7'd21: q = 17'd23486; 7'd22: q = 17'd24550; 7'd23: q = 17'd25607;
      7'd24: q = 17'd26656; 7'd25: q = 17'd27697; 7'd26: q = 17'd28729; 7'd27: q = 17'd29753;
      7'd28: q = 17'd30767; 7'd29: q = 17'd31772; 7'd30: q = 17'd32768; 7'd31: q = 17'd33754;
      7'd32: q = 17'd34729; 7'd33: q = 17'd35693; 7'd34: q = 17'd36647; 7'd35: q = 17'd37590;
      7'd36: q = 17'd38521; 7'd37: q = 17'd39441; 7'd38: q = 17'd40348; 7'd39: q = 17'd41243;
      7'd40: q = 17'd42126; 7'd41: q = 17'd42995; 7'd42: q = 17'd43852; 7'd43: q = 17'd44695;
      7'd44: q = 17'd45525; 7'd45: q = 17'd46341; 7'd46: q = 17'd47143; 7'd47: q = 17'd47930;
      7'd48: q = 17'd48703; 7'd49: q = 17'd49461; 7'd50: q = 17'd50203; 7'd51: q = 17'd50931;
      7'd52: q = 17'd51643; 7'd53: q = 17'd52339; 7'd54: q = 17'd53020; 7'd55: q = 17'd53684;
      7'd56: q = 17'd54332; 7'd57: q = 17'd54963; 7'd58: q = 17'd55578; 7'd59: q = 17'd56175;
      7'd60: q = 17'd56756; 7'd61: q = 17'd57319; 7'd62: q = 17'd57865; 7'd63: q = 17'd58393;
      7'd64: q = 17'd58903; 7'd65: q = 17'd59396; 7'd66: q = 17'd59870; 7'd67: q = 17'd60326;
      7'd68: q = 17'd60764; 7'd69: q = 17'd61183; 7'd70: q = 17'd61584; 7'd71: q = 17'd61966;
      7'd72: q = 17'd62328; 7'd73: q = 17'd62672; 7'd74: q = 17'd62997; 7'd75: q = 17'd63303;
      7'd76: q = 17'd63589; 7'd77: q = 17'd63856; 7'd78: q = 17'd64104; 7'd79: q = 17'd64332;
      7'd80: q = 17'd64540; 7'd81: q = 17'd64729; 7'd82: q = 17'd64898; 7'd83: q = 17'd65048;
      7'd84: q = 17'd65177; 7'd85: q = 17'd65287; 7'd86: q = 17'd65376; 7'd87: q = 17'd65446;
      7'd88: q = 17'd65496; 7'd89: q = 17'd65526;
      default: q = 17'd65536;
    endcase
    w = ROM_W'(q);
    if (frac >= ROM_FRAC) begin
      w = w << (frac - ROM_FRAC);
    end else begin
      dn = ROM_FRAC - frac;
      w  = (w + (ROM_W'(1) << (dn - 1))) >> dn;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/core/p2cc_in_if.sv]
// Input channel: heading and signed magnitude with valid/ready.
`default_nettype none

interface p2cc_in_if
  import p2cc_pkg::*;
#(
  parameter int MAG_WIDTH = MAG_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [AZ_WIDTH-1:0]  azimuth_deg;
  logic signed [MAG_WIDTH-1:0] magnitude;

  modport source (output valid, azimuth_deg, magnitude, input ready);
  modport sink   (input valid, azimuth_deg, magnitude, output ready);
endinterface

`default_nettype wire

[rtl/core/p2cc_out_if.sv]
// Result channel: x and y coordinates with valid/ready.
`default_nettype none

interface p2cc_out_if
  import p2cc_pkg::*;
#(
  parameter int MAG_WIDTH = MAG_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [MAG_WIDTH-1:0] x_coord;
  logic signed [MAG_WIDTH-1:0] y_coord;

  modport source (output valid, x_coord, y_coord, input ready);
  modport sink   (input valid, x_coord, y_coord, output ready);
endinterface

`default_nettype wire

[rtl/core/polar_to_cartesian_compass.sv]
// Top level: pipelined compass polar to Cartesian converter.
`default_nettype none

// Converts a whole-degree compass heading (clockwise from +y) and a signed
// magnitude into x = round(m*sin(az)), y = round(m*cos(az)), rounded half
// away from zero; a negative magnitude points the opposite way. The block
// takes one transfer per clock unless a stalled output backs up into a full
// pipeline, and holds no state between items. Each item passes six register
// stages (heading offset and absolute magnitude, modulo 360 reduction,
// quadrant fold, sine table, multiply, round and saturate), one register
// per step. Each stage advances on its own when the next one is empty or
// moving, so gaps close up and input ready drops only when all six stages
// hold an item and the output is stalled. Throughput is one item per clock
// while the output is not stalled.
module polar_to_cartesian_compass
  import p2cc_pkg::*;
#(
  parameter int MAG_WIDTH      = MAG_WIDTH_DEF,
  parameter int SINE_FRAC_BITS = SINE_FRAC_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  p2cc_in_if.sink     in_ch,
  p2cc_out_if.source  out_ch
);

  `include "polar_to_cartesian_compass_defines.svh"

  localparam int SW = SINE_FRAC_BITS + 1;
  localparam int PW = MAG_WIDTH + SW;
  localparam logic [PW-1:0] MAXPOS = PW'((64'd1 << (MAG_WIDTH - 1)) - 64'd1);
  localparam logic [PW-1:0] HALF_LSB = PW'(64'd1 << (SINE_FRAC_BITS - 1));

  typedef struct packed {
    logic             neg;
    logic [IDX_W-1:0] idx;
  } fold_t;

  // Map an angle 0..359 to a table index and the sign of its sine
  function automatic fold_t fold(input logic [ANG_W-1:0] a);
    fold_t f;
    f.neg = (a > ANG_W'(HALF_TURN));
    if (a <= ANG_W'(QUARTER_TURN)) begin
      f.idx = IDX_W'(a);
    end else if (a <= ANG_W'(HALF_TURN)) begin
      f.idx = IDX_W'(ANG_W'(HALF_TURN) - a);
    end else if (a <= ANG_W'(HALF_TURN + QUARTER_TURN)) begin
      f.idx = IDX_W'(a - ANG_W'(HALF_TURN));
    end else begin
      f.idx = IDX_W'(ANG_W'(FULL_TURN) - a);
    end
    return f;
  endfunction

  // Round the product, clamp and apply the sign
  function automatic logic [MAG_WIDTH-1:0] finish(input logic [PW-1:0] p,
                                                   input logic neg);
    logic [PW-1:0] r;
    logic [PW-1:0] c;
    r = (p + HALF_LSB) >> SINE_FRAC_BITS;
    if (!neg) begin
      c = (r > MAXPOS) ? MAXPOS : r;
    end else begin
      c = (r > MAXPOS + PW'(1)) ? MAXPOS + PW'(1) : r;
      c = PW'(0) - c;
    end
    return MAG_WIDTH'(c);
  endfunction

  // Stage valid bits and per-stage advance enables
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 0: offset heading into a positive range, take |magnitude|
  logic                 in_neg;
  logic [SUM_W-1:0]     sum_nxt;
  logic [MAG_WIDTH-1:0] mag_nxt;
  logic [SUM_W-1:0]     sum_r;
  logic [MAG_WIDTH-1:0] mag0_r;

  always_comb begin
    in_neg  = in_ch.magnitude[MAG_WIDTH-1];
    mag_nxt = in_neg ? (~$unsigned(in_ch.magnitude) + MAG_WIDTH'(1))
                     : $unsigned(in_ch.magnitude);
    sum_nxt = $unsigned(SUM_W'(in_ch.azimuth_deg)) + SUM_W'(3 * FULL_TURN)
            + (in_neg ? SUM_W'(HALF_TURN) : SUM_W'(0));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sum_r  <= sum_nxt;
      mag0_r <= mag_nxt;
    end
  end

  // Stage 1: reduce modulo 360 by three compare-and-subtract steps
  logic [SUM_W-1:0]     red;
  logic [ANG_W-1:0]     ang_r;
  logic [MAG_WIDTH-1:0] mag1_r;

  always_comb begin
    red = sum_r;
    if (red >= SUM_W'(4 * FULL_TURN)) begin
      red = red - SUM_W'(4 * FULL_TURN);
    end
    if (red >= SUM_W'(2 * FULL_TURN)) begin
      red = red - SUM_W'(2 * FULL_TURN);
    end
    if (red >= SUM_W'(FULL_TURN)) begin
      red = red - SUM_W'(FULL_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ang_r  <= ANG_W'(red);
      mag1_r <= mag0_r;
    end
  end

  // Stage 2: form the cosine angle and fold both into the first quadrant
  logic [ANG_W-1:0]     cos_ang;
  fold_t                fx_r;
  fold_t                fy_r;
  logic [MAG_WIDTH-1:0] mag2_r;

  always_comb begin
    cos_ang = ang_r + ANG_W'(QUARTER_TURN);
    if (cos_ang >= ANG_W'(FULL_TURN)) begin
      cos_ang = cos_ang - ANG_W'(FULL_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      fx_r   <= fold(ang_r);
      fy_r   <= fold(cos_ang);
      mag2_r <= mag1_r;
    end
  end

  // Stage 3: sine table lookups
  logic [SW-1:0]        sin_x_r;
  logic [SW-1:0]        sin_y_r;
  logic                 neg_x3_r;
  logic                 neg_y3_r;
  logic [MAG_WIDTH-1:0] mag3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sin_x_r  <= SW'(sine_rom(fx_r.idx, SINE_FRAC_BITS));
      sin_y_r  <= SW'(sine_rom(fy_r.idx, SINE_FRAC_BITS));
      neg_x3_r <= fx_r.neg;
      neg_y3_r <= fy_r.neg;
      mag3_r   <= mag2_r;
    end
  end

  // Stage 4: unsigned products
  logic [PW-1:0] prod_x_r;
  logic [PW-1:0] prod_y_r;
  logic          neg_x4_r;
  logic          neg_y4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      prod_x_r <= PW'(mag3_r) * PW'(sin_x_r);
      prod_y_r <= PW'(mag3_r) * PW'(sin_y_r);
      neg_x4_r <= neg_x3_r;
      neg_y4_r <= neg_y3_r;
    end
  end

  // Stage 5: round, saturate, sign; hold while the output stalls
  logic [MAG_WIDTH-1:0] x_r;
  logic [MAG_WIDTH-1:0] y_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      x_r <= finish(prod_x_r, neg_x4_r);
      y_r <= finish(prod_y_r, neg_y4_r);
    end
  end

  assign out_ch.valid   = v_r[NSTG-1];
  assign out_ch.x_coord = $signed(x_r);
  assign out_ch.y_coord = $signed(y_r);

  `P2CC_ASSERT_IMPL(a_ang_range, v_r[1], ang_r < ANG_W'(FULL_TURN),
                    "reduced heading out of range")
  `P2CC_ASSERT_IMPL(a_fold_range,
                    v_r[2],
                    (fx_r.idx <= IDX_W'(QUARTER_TURN))
                      && (fy_r.idx <= IDX_W'(QUARTER_TURN)),
                    "folded table index beyond a quarter turn")
  `P2CC_ASSERT_IMPL(a_quadrature, v_r[3], (sin_x_r != '0) || (sin_y_r != '0),
                    "sine and cosine both zero")
  `P2CC_ASSERT_NEXT(a_prod_hold, v_r[4] && !en[4],
                    v_r[4] && $stable(prod_x_r) && $stable(prod_y_r),
                    "stalled product stage lost its item")
  `P2CC_ASSERT_IMPL(a_ready_full, !en[0], &v_r,
                    "input blocked while the pipeline has a bubble")

endmodule

`default_nettype wire
